// ===== rtl/rhs_pkg.sv =====
// Shared types and constants for the random-hyperplane signature block.
// Used by the channel interfaces and all rhs_* modules.
package rhs_pkg;

  localparam int NUM_PLANES_DEF  = 16;
  localparam int FEATURE_DIM_DEF = 64;

  localparam int PLANE_IDX_W = 4;
  localparam int ELEM_IDX_W  = 6;
  localparam int VALUE_W     = 16;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int ACC_W       = 38;
  localparam int SIG_W       = 16;

  // Result slots in the output queue; also the credit limit on closed vectors not yet delivered.
  localparam int OUT_DEPTH   = 8;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_FEATURE = 1'b1
  } cmd_t;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SIG_W-1:0]          sig_t;

  // Control that travels beside a feature element through the MAC pipeline.
  typedef struct packed {
    logic valid;   // feature element present
    logic accum;   // element index in range: add the products
    logic last;    // emit the signature and clear
  } mac_ctl_t;

endpackage

// ===== rtl/rhs_req_if.sv =====
// Request channel of the signature block: load or feature element.
// Depends on rhs_pkg for field widths.
interface rhs_req_if;
  logic                               valid;
  logic                               ready;
  rhs_pkg::cmd_t                      command;
  logic [rhs_pkg::PLANE_IDX_W-1:0]    plane_index;
  logic [rhs_pkg::ELEM_IDX_W-1:0]     element_index;
  rhs_pkg::value_t                    value;
  logic                               last;

  modport source (output valid, command, plane_index, element_index, value, last,
                  input ready);
  modport sink   (input valid, command, plane_index, element_index, value, last,
                  output ready);
endinterface

// ===== rtl/rhs_sig_if.sv =====
// Result channel of the signature block: one signature word per vector.
// Depends on rhs_pkg for the signature width.
interface rhs_sig_if;
  logic          valid;
  logic          ready;
  rhs_pkg::sig_t signature;

  modport source (output valid, signature, input ready);
  modport sink   (input valid, signature, output ready);
endinterface

// ===== rtl/random_hyperplane_signature_core.sv =====
// Random-hyperplane signature (SimHash) core.
// Request channel req: command 0 writes coefficient value into plane
// plane_index at element_index; command 1 brings one signed Q4.12 feature
// element, multiplied by every plane's coefficient at that index and added
// into that plane's 38-bit accumulator. On a feature request with last set,
// one result goes out on sig: bit k set when plane k's dot product is > 0;
// the accumulators then clear. Loads and other elements give no result.
// Throughput: one request per cycle while req.ready is high, set by the single
// read port of the coefficient memory lanes and the MAC lanes.
// Path: a last element's signature passes the memory read, the multiply, the
// accumulate and sign test, and the queue write before it appears on sig.
// Stall: up to 8 signatures wait in the output queue; req.ready drops only
// while 8 vectors are closed but not yet delivered.
// Reset clears accumulators, pipeline control and the queue. Coefficient
// memory is not cleared: load every coefficient before using it.
module random_hyperplane_signature_core #(
  parameter int NUM_PLANES  = rhs_pkg::NUM_PLANES_DEF,
  parameter int FEATURE_DIM = rhs_pkg::FEATURE_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rhs_req_if.sink   req,
  rhs_sig_if.source sig
);

  localparam int AW = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;

  logic                                   accept;
  logic                                   elem_ok;
  logic                                   wr_en;
  logic                                   rd_en;
  logic [AW-1:0]                          addr;
  logic [NUM_PLANES*rhs_pkg::VALUE_W-1:0] coef;
  rhs_pkg::mac_ctl_t                      ctl;
  rhs_pkg::value_t                        x;
  logic                                   mac_valid;
  rhs_pkg::sig_t                          mac_sig;
  logic [rhs_pkg::OUT_CNT_W-1:0]          used;
  logic                                   take;
  logic                                   give;

  assign accept  = req.valid && req.ready;
  assign elem_ok = (32'(req.element_index) < FEATURE_DIM);
  assign addr    = AW'(req.element_index);
  assign wr_en   = accept && (req.command == rhs_pkg::CMD_LOAD) && elem_ok;
  assign rd_en   = accept && (req.command == rhs_pkg::CMD_FEATURE);

  // Credit: one slot per closed vector until its signature is taken.
  assign take      = rd_en && req.last;
  assign give      = sig.valid && sig.ready;
  assign req.ready = (used != rhs_pkg::OUT_CNT_W'(rhs_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + rhs_pkg::OUT_CNT_W'(take) - rhs_pkg::OUT_CNT_W'(give);
    end
  end

  // Align element data with the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= rd_en;
      ctl.accum <= elem_ok;
      ctl.last  <= req.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      x <= req.value;
    end
  end

  rhs_coef_mem #(
    .NUM_PLANES  (NUM_PLANES),
    .FEATURE_DIM (FEATURE_DIM)
  ) u_coef_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_plane (req.plane_index),
    .addr     (addr),
    .wr_data  (req.value),
    .rd_en    (rd_en),
    .rd_data  (coef)
  );

  rhs_mac #(
    .NUM_PLANES (NUM_PLANES)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .x         (x),
    .coef      (coef),
    .sig_valid (mac_valid),
    .sig       (mac_sig)
  );

  rhs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mac_valid),
    .push_data (mac_sig),
    .sig       (sig)
  );

endmodule

// ===== rtl/rhs_coef_mem.sv =====
// Hyperplane coefficient store: one synchronous memory lane per plane,
// addressed by element index, all lanes read together. Depends on rhs_pkg.
module rhs_coef_mem #(
  parameter int NUM_PLANES  = rhs_pkg::NUM_PLANES_DEF,
  parameter int FEATURE_DIM = rhs_pkg::FEATURE_DIM_DEF,
  localparam int AW = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [rhs_pkg::PLANE_IDX_W-1:0]        wr_plane,
  input  logic [AW-1:0]                          addr,
  input  rhs_pkg::value_t                        wr_data,
  input  logic                                   rd_en,
  output logic [NUM_PLANES*rhs_pkg::VALUE_W-1:0] rd_data
);

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_lane
    logic [rhs_pkg::VALUE_W-1:0] mem [FEATURE_DIM];
    logic [rhs_pkg::VALUE_W-1:0] rd_q;
    logic                        sel;

    assign sel = (32'(wr_plane) == k);

    always_ff @(posedge clk) begin
      if (wr_en && sel) begin
        mem[addr] <= wr_data;
      end
      if (rd_en) begin
        rd_q <= mem[addr];
      end
    end

    assign rd_data[k*rhs_pkg::VALUE_W +: rhs_pkg::VALUE_W] = rd_q;
  end

endmodule

// ===== rtl/rhs_mac.sv =====
// Per-plane multiply-accumulate lanes: product stage, then accumulate and
// sign test on the last element. Depends on rhs_pkg.
module rhs_mac #(
  parameter int NUM_PLANES = rhs_pkg::NUM_PLANES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rhs_pkg::mac_ctl_t                      ctl,
  input  rhs_pkg::value_t                        x,
  input  logic [NUM_PLANES*rhs_pkg::VALUE_W-1:0] coef,
  output logic                                   sig_valid,
  output rhs_pkg::sig_t                          sig
);

  rhs_pkg::mac_ctl_t       ctl_p;
  logic [NUM_PLANES-1:0]   pos;
  rhs_pkg::sig_t           sig_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p     <= '0;
      sig_valid <= 1'b0;
    end else begin
      ctl_p     <= ctl;
      sig_valid <= ctl_p.valid && ctl_p.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_p.valid && ctl_p.last) begin
      sig <= sig_next;
    end
  end

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_lane
    rhs_pkg::value_t                   c;
    logic signed [rhs_pkg::PROD_W-1:0] prod;
    logic [rhs_pkg::ACC_W-1:0]         acc;
    logic [rhs_pkg::ACC_W-1:0]         sum;

    assign c = coef[k*rhs_pkg::VALUE_W +: rhs_pkg::VALUE_W];

    // Out-of-range elements contribute a zero product.
    always_ff @(posedge clk) begin
      if (ctl.valid) begin
        if (ctl.accum) begin
          prod <= x * c;
        end else begin
          prod <= '0;
        end
      end
    end

    assign sum = acc + {{(rhs_pkg::ACC_W-rhs_pkg::PROD_W){prod[rhs_pkg::PROD_W-1]}}, prod};
    assign pos[k] = (sum != '0) && !sum[rhs_pkg::ACC_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        acc <= '0;
      end else if (ctl_p.valid) begin
        acc <= ctl_p.last ? '0 : sum;
      end
    end
  end

  for (genvar i = 0; i < rhs_pkg::SIG_W; i++) begin : g_sig
    if (i < NUM_PLANES) begin : g_on
      assign sig_next[i] = pos[i];
    end else begin : g_off
      assign sig_next[i] = 1'b0;
    end
  end

endmodule

// ===== rtl/rhs_out_fifo.sv =====
// Small result queue between the MAC lanes and the result channel.
// Depends on rhs_pkg; the producer is kept from overrunning by credits.
module rhs_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rhs_pkg::sig_t push_data,
  rhs_sig_if.source     sig
);

  rhs_pkg::sig_t                   slots [rhs_pkg::OUT_DEPTH];
  logic [rhs_pkg::OUT_PTR_W-1:0]   wr_ptr;
  logic [rhs_pkg::OUT_PTR_W-1:0]   rd_ptr;
  logic [rhs_pkg::OUT_CNT_W-1:0]   count;
  logic                            pop;

  assign pop           = sig.valid && sig.ready;
  assign sig.valid     = (count != '0);
  assign sig.signature = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + rhs_pkg::OUT_CNT_W'(push) - rhs_pkg::OUT_CNT_W'(pop);
    end
  end

endmodule
